### rtl/core/multi_channel_edge_interval_capture_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the edge interval capture block
// Concurrent checks clocked on clk_i; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_EDGE_INTERVAL_CAPTURE_MACROS_SVH
`define MULTI_CHANNEL_EDGE_INTERVAL_CAPTURE_MACROS_SVH

`ifndef SYNTHESIS
// check held outside reset
`define MCEIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check that also holds while reset is applied
`define MCEIC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MCEIC_ASSERT(lbl, prop, msg)
`define MCEIC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/mceic_pkg.sv
// ----------------------------------------------------------------------------
// mceic_pkg
// Shared types and constants of the edge interval capture block.
// ----------------------------------------------------------------------------
package mceic_pkg;

  localparam int NUM_STAMPS   = 4;
  localparam int CHANNELS_DEF = 4;
  localparam int MAX_EDGES_DEF = 32;

  localparam int STAMP_W = 16;
  localparam int COUNT_W = 6;
  localparam int CH_W    = 2;
  localparam int FLAGS_W = 4;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [STAMP_W-1:0] GAP_RESET    = 16'd2000;
  localparam logic [STAMP_W-1:0] BUDGET_RESET = 16'd50000;
  localparam logic [STAMP_W-1:0] STAMP_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_ARM    = 2'd0,
    REQ_POLL   = 2'd1,
    REQ_CANCEL = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_INTERVAL = 2'd0,
    KIND_CLOSE    = 2'd1,
    KIND_ACK      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CLOSE_FULL   = 2'd0,
    CLOSE_QUIET  = 2'd1,
    CLOSE_BUDGET = 2'd2
  } reason_e;

  typedef enum logic {
    REG_QUIET_GAP   = 1'b0,
    REG_POLL_BUDGET = 1'b1
  } reg_e;

  typedef struct packed {
    kind_e               kind;
    logic [CH_W-1:0]     ch;
    logic [STAMP_W-1:0]  interval;
    logic [COUNT_W-1:0]  count;
    reason_e             reason;
    logic                acc;
  } result_t;

  typedef struct packed {
    logic                poll;
    logic                arm;
    logic                cancel;
    logic                close;
    logic [COUNT_W-1:0]  cap;
  } lane_ctrl_t;

  typedef struct packed {
    logic                armed;
    logic                full;
    logic                primed;
    logic                hit;
    logic                rec;
    logic [STAMP_W-1:0]  interval;
    logic [COUNT_W-1:0]  count;
  } lane_stat_t;

endpackage

### rtl/core/mceic_lane.sv
// ----------------------------------------------------------------------------
// mceic_lane
// Per-channel capture state: previous stamp, interval count and capacity.
// ----------------------------------------------------------------------------
module mceic_lane import mceic_pkg::*; #(
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_ctrl_t         ctrl_i,
  input  logic               flag_i,
  input  logic [STAMP_W-1:0] stamp_i,
  output lane_stat_t         stat_o
);

  logic [STAMP_W-1:0] prev_q, prev_d;
  logic               primed_q, primed_d;
  logic               armed_q, armed_d;
  logic [COUNT_W-1:0] stored_q, stored_d;
  logic [COUNT_W-1:0] cap_q, cap_d;

  logic               full;
  logic               hit;
  logic               rec;
  logic [STAMP_W-1:0] diff;
  logic [COUNT_W-1:0] cap_clamped;

  assign full = (stored_q >= cap_q);
  assign hit  = ctrl_i.poll && armed_q && flag_i;
  assign rec  = hit && primed_q && !full;
  assign diff = stamp_i - prev_q;

  assign cap_clamped = (32'(ctrl_i.cap) > MAX_EDGES) ? COUNT_W'(MAX_EDGES) : ctrl_i.cap;

  always_comb begin
    prev_d   = prev_q;
    primed_d = primed_q;
    armed_d  = armed_q;
    stored_d = stored_q;
    cap_d    = cap_q;
    if (ctrl_i.arm) begin
      cap_d    = cap_clamped;
      stored_d = '0;
      armed_d  = 1'b1;
      primed_d = 1'b0;
      prev_d   = '0;
    end else if (ctrl_i.cancel) begin
      armed_d  = 1'b0;
      stored_d = '0;
      cap_d    = '0;
      primed_d = 1'b0;
    end else if (ctrl_i.poll) begin
      if (hit) begin
        prev_d   = stamp_i;
        primed_d = 1'b1;
      end
      if (rec) begin
        stored_d = stored_q + 1'b1;
      end
      if (ctrl_i.close) begin
        armed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      primed_q <= 1'b0;
      armed_q  <= 1'b0;
      stored_q <= '0;
      cap_q    <= '0;
    end else begin
      prev_q   <= prev_d;
      primed_q <= primed_d;
      armed_q  <= armed_d;
      stored_q <= stored_d;
      cap_q    <= cap_d;
    end
  end

  always_comb begin
    stat_o.armed    = armed_q;
    stat_o.full     = full;
    stat_o.primed   = primed_q;
    stat_o.hit      = hit;
    stat_o.rec      = rec;
    stat_o.interval = (diff == '0) ? STAMP_W'(1) : diff;
    stat_o.count    = stored_q + 1'b1;
  end

endmodule

### rtl/core/mceic_merge.sv
// ----------------------------------------------------------------------------
// mceic_merge
// Holds the results of one item and sends them out one per cycle while the
// output is not stalled, in lane order, through an output register.
// ----------------------------------------------------------------------------
module mceic_merge import mceic_pkg::*; #(
  parameter int SLOTS = NUM_STAMPS + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [SLOTS-1:0]      mask_i,
  input  result_t               slots_i [SLOTS],
  output logic                  free_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // channel, interval, edge_count, reason, accepted
  output logic [1:0]            m_axis_tuser,  // kind
  output logic                  m_axis_tlast
);

  logic [SLOTS-1:0] mask_q, mask_d;
  result_t          slots_q [SLOTS];
  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  logic             last_q;

  logic             adv;
  logic [SLOTS-1:0] pick;
  logic [SLOTS-1:0] rest;
  result_t          sel;

  assign pick = mask_q & (~mask_q + 1'b1);
  assign rest = mask_q & ~pick;
  assign adv  = (mask_q != '0) && (!out_valid_q || m_axis_tready);

  assign free_o = (mask_q == '0) || (adv && (rest == '0));

  always_comb begin
    sel = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pick[i]) begin
        sel = sel | slots_q[i];
      end
    end
  end

  always_comb begin
    if (load_i) begin
      mask_d = mask_i;
    end else if (adv) begin
      mask_d = rest;
    end else begin
      mask_d = mask_q;
    end
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slots_q <= slots_i;
    end
    if (adv) begin
      out_q  <= sel;
      last_q <= (rest == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.acc, out_q.reason, out_q.count, out_q.interval, out_q.ch};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = last_q;

endmodule

### rtl/core/multi_channel_edge_interval_capture.sv
// ----------------------------------------------------------------------------
// multi_channel_edge_interval_capture
// Listen window over four capture channels, reporting edge intervals.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser carries the request (arm, poll, cancel), tdata
// the channel, capacity, capture flags and four 16-bit timestamps.
// Output stream: one result per item transfer; tuser gives its kind, tlast
// marks the last result caused by an input item. An arm or cancel gives one
// acknowledgement, a poll gives up to four intervals plus a close result,
// an ignored poll gives nothing.
// Timing: all lanes update in the cycle an item is taken; its results pass
// the merge slots, then the output register. Unless m_axis stalls, the merge
// stage drains one result per cycle, an item holds the input until its last
// result moves out, and items with at most one result stream at one per
// cycle. The output register decouples the sides: with a result waiting on
// a stalled output, one more item with results is parked; later items wait.
// Reset clears all channels and counters and loads quiet_gap = 2000 and
// poll_budget = 50000. Issue APB writes only while no item is in flight.
// ----------------------------------------------------------------------------
`include "multi_channel_edge_interval_capture_macros.svh"

module multi_channel_edge_interval_capture import mceic_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // channel[1:0], capacity[7:2], edge_flags[11:8], stamp_ch0..3 [75:12]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,  // req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_channel[1:0], interval[17:2], edge_count[23:18], close_reason[25:24],
  // accepted[26]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser,  // kind
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  localparam int LANES = (CHANNELS < NUM_STAMPS) ? CHANNELS : NUM_STAMPS;
  localparam int SLOTS = LANES + 1;

  // configuration
  logic [STAMP_W-1:0] gap_q, budget_q;
  reg_e               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q    <= GAP_RESET;
      budget_q <= BUDGET_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_QUIET_GAP:   gap_q    <= pwdata[STAMP_W-1:0];
        REG_POLL_BUDGET: budget_q <= pwdata[STAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_QUIET_GAP:   prdata = {16'b0, gap_q};
      REG_POLL_BUDGET: prdata = {16'b0, budget_q};
      default:         prdata = '0;
    endcase
  end

  // input decode
  logic               accept;
  req_e               req;
  logic [CH_W-1:0]    channel;
  logic [COUNT_W-1:0] capacity;
  logic [FLAGS_W-1:0] edge_flags;
  logic               ch_ok, is_arm, is_poll, is_cancel;
  logic               arm_ok, cancel_ok, poll_ok, ack_item;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign req        = req_e'(s_axis_tuser);
  assign channel    = s_axis_tdata[1:0];
  assign capacity   = s_axis_tdata[7:2];
  assign edge_flags = s_axis_tdata[11:8];
  assign ch_ok      = 32'(channel) < CHANNELS;

  always_comb begin
    is_arm    = 1'b0;
    is_poll   = 1'b0;
    is_cancel = 1'b0;
    unique case (req)
      REQ_ARM:    is_arm    = 1'b1;
      REQ_POLL:   is_poll   = 1'b1;
      REQ_CANCEL: is_cancel = 1'b1;
      default: ;
    endcase
  end

  // lanes
  lane_ctrl_t       ctrl [LANES];
  lane_stat_t       stat [LANES];
  logic [LANES-1:0] armed_vec, full_vec, prev_vec, hit_vec, rec_vec;
  logic             any_armed, all_full, saw, edge_seen, close_w;

  assign any_armed = |armed_vec;
  assign arm_ok    = accept && is_arm && ch_ok && (capacity != '0);
  assign cancel_ok = accept && is_cancel && ch_ok;
  assign poll_ok   = accept && is_poll && any_armed;
  assign ack_item  = accept && (is_arm || is_cancel);

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    always_comb begin
      ctrl[c].poll   = poll_ok;
      ctrl[c].arm    = arm_ok && (32'(channel) == c);
      ctrl[c].cancel = cancel_ok && (32'(channel) == c);
      ctrl[c].close  = close_w;
      ctrl[c].cap    = capacity;
    end

    mceic_lane #(
      .MAX_EDGES(MAX_EDGES)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[c]),
      .flag_i (edge_flags[c]),
      .stamp_i(s_axis_tdata[12 + STAMP_W*c +: STAMP_W]),
      .stat_o (stat[c])
    );

    assign armed_vec[c] = stat[c].armed;
    assign full_vec[c]  = !stat[c].armed || stat[c].full;
    assign prev_vec[c]  = stat[c].armed && stat[c].primed;
    assign hit_vec[c]   = stat[c].hit;
    assign rec_vec[c]   = stat[c].rec;
  end

  assign all_full  = &full_vec;
  assign saw       = |hit_vec;
  assign edge_seen = |prev_vec;

  // window counters
  logic [STAMP_W-1:0] quiet_q, quiet_d, polls_q, polls_d;
  logic [STAMP_W-1:0] quiet_inc, polls_inc;
  logic               close_any;
  reason_e            reason;

  assign quiet_inc = (quiet_q == STAMP_MAX) ? quiet_q : quiet_q + 1'b1;
  assign polls_inc = (polls_q == STAMP_MAX) ? polls_q : polls_q + 1'b1;

  always_comb begin
    close_any = 1'b1;
    reason    = CLOSE_FULL;
    quiet_d   = quiet_q;
    priority if (all_full) begin
      reason = CLOSE_FULL;
    end else if (saw) begin
      quiet_d   = '0;
      close_any = polls_inc >= budget_q;
      reason    = CLOSE_BUDGET;
    end else if (edge_seen && (quiet_inc >= gap_q)) begin
      quiet_d = quiet_inc;
      reason  = CLOSE_QUIET;
    end else begin
      // quiet timer runs only once an armed channel has seen an edge
      if (edge_seen) begin
        quiet_d = quiet_inc;
      end
      close_any = polls_inc >= budget_q;
      reason    = CLOSE_BUDGET;
    end
  end

  assign close_w = poll_ok && close_any;

  always_comb begin
    polls_d = polls_q;
    if (arm_ok && !any_armed) begin
      polls_d = '0;
    end else if (poll_ok) begin
      polls_d = close_any ? '0 : polls_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_q <= '0;
      polls_q <= '0;
    end else begin
      polls_q <= polls_d;
      if (arm_ok && !any_armed) begin
        quiet_q <= '0;
      end else if (poll_ok) begin
        quiet_q <= close_any ? '0 : quiet_d;
      end
    end
  end

  // result slots: lane intervals, then close; an acknowledgement uses slot 0
  result_t          slots [SLOTS];
  logic [SLOTS-1:0] mask;

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      slots[c].kind     = KIND_INTERVAL;
      slots[c].ch       = CH_W'(c);
      slots[c].interval = stat[c].interval;
      slots[c].count    = stat[c].count;
      slots[c].reason   = CLOSE_FULL;
      slots[c].acc      = 1'b0;
      mask[c]           = poll_ok && rec_vec[c];
    end
    slots[LANES]      = '0;
    slots[LANES].kind = KIND_CLOSE;
    slots[LANES].reason = reason;
    mask[LANES]       = close_w;
    if (ack_item) begin
      slots[0]      = '0;
      slots[0].kind = KIND_ACK;
      slots[0].ch   = channel;
      slots[0].acc  = arm_ok || cancel_ok;
      mask          = SLOTS'(1);
    end
  end

  mceic_merge #(
    .SLOTS(SLOTS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .mask_i       (mask),
    .slots_i      (slots),
    .free_o       (s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // output side views for the checks below
  logic out_close, out_interval;

  assign out_close    = m_axis_tvalid && (m_axis_tuser == KIND_CLOSE);
  assign out_interval = m_axis_tvalid && (m_axis_tuser == KIND_INTERVAL);

  `MCEIC_ASSERT(a_close_disarms, close_w |=> (armed_vec == '0), "close left a channel armed")
  `MCEIC_ASSERT(a_close_is_last, out_close |-> m_axis_tlast, "close result not last")
  `MCEIC_ASSERT(a_interval_nonzero, out_interval |-> (m_axis_tdata[17:2] != '0), "zero interval")

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for multi_channel_edge_interval_capture. Drives arm,
// cancel and poll items with random flow control on both streams, tracks the
// channel state in a local predictor and checks every output item field by
// field, across several quiet gap and poll budget settings.
// ----------------------------------------------------------------------------
module tb import mceic_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 500000;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  ch;
    logic [15:0] interval;
    logic [5:0]  count;
    reason_e     reason;
    logic        acc;
    logic        last;
  } capture_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [PADDR_W-1:0]    paddr         = '0;
  logic [PDATA_W-1:0]    pwdata        = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // predicted channel state and registers
  logic [15:0] last_stamp [4]  = '{default: '0};
  logic [5:0]  chan_count [4]  = '{default: '0};
  logic [5:0]  chan_cap   [4]  = '{default: '0};
  logic [3:0]  stamp_valid     = '0;
  logic [3:0]  chan_on         = '0;
  logic [15:0] quiet_polls     = '0;
  logic [15:0] window_polls    = '0;
  logic [15:0] cfg_gap         = GAP_RESET;
  logic [15:0] cfg_budget      = BUDGET_RESET;

  capture_t    due_results [$];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  items_sent   = 0;
  int  items_active = 0;
  int  cycles       = 0;
  int  closes [4]   = '{default: 0};
  int  sink_wait    = 0;
  bit  src_fast     = 1'b0;
  bit  sink_fast    = 1'b0;

  always #2 clk_i = ~clk_i;

  multi_channel_edge_interval_capture uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("tb: mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
  endtask

  function automatic void queue_result(kind_e k, logic [1:0] c, logic [15:0] iv,
                                       logic [5:0] n, reason_e r, logic a);
    capture_t e;
    e = '{kind: k, ch: c, interval: iv, count: n, reason: r, acc: a, last: 1'b0};
    due_results.push_back(e);
  endfunction

  // Updates the channel state for one accepted item and queues its results.
  function automatic int predict_capture(logic [1:0] req, logic [1:0] ch, logic [5:0] cap,
                                         logic [3:0] flags, logic [63:0] stamps);
    int          n;
    int          c;
    logic        acc;
    logic        full;
    logic        saw;
    logic        closing;
    logic [15:0] stamp;
    logic [15:0] delta;
    reason_e     why;
    n = 0;
    if (req == REQ_ARM || req == REQ_CANCEL) begin
      acc = 1'b0;
      if (req == REQ_ARM && cap != '0) begin
        // first arm of a window restarts both counters
        if (chan_on == '0) begin
          quiet_polls  = '0;
          window_polls = '0;
        end
        chan_cap[ch]    = (cap > MAX_EDGES_DEF) ? 6'(MAX_EDGES_DEF) : cap;
        chan_count[ch]  = '0;
        chan_on[ch]     = 1'b1;
        stamp_valid[ch] = 1'b0;
        last_stamp[ch]  = '0;
        acc = 1'b1;
      end else if (req == REQ_CANCEL) begin
        chan_on[ch]     = 1'b0;
        chan_count[ch]  = '0;
        chan_cap[ch]    = '0;
        stamp_valid[ch] = 1'b0;
        acc = 1'b1;
      end
      queue_result(KIND_ACK, ch, '0, '0, CLOSE_FULL, acc);
      due_results[due_results.size()-1].last = 1'b1;
      return 1;
    end
    if (req != REQ_POLL || chan_on == '0) begin
      return 0;
    end

    full    = 1'b1;
    saw     = 1'b0;
    closing = 1'b0;
    why     = CLOSE_FULL;
    for (c = 0; c < 4; c++) begin
      if (chan_on[c]) begin
        if (chan_count[c] < chan_cap[c]) begin
          full = 1'b0;
        end
        if (flags[c]) begin
          stamp = stamps[16*c +: 16];
          if (stamp_valid[c] && chan_count[c] < chan_cap[c]) begin
            delta = stamp - last_stamp[c];
            if (delta == '0) begin
              delta = 16'd1;
            end
            chan_count[c]++;
            queue_result(KIND_INTERVAL, 2'(c), delta, chan_count[c], CLOSE_FULL, 1'b0);
            n++;
          end
          last_stamp[c]  = stamp;
          stamp_valid[c] = 1'b1;
          saw = 1'b1;
        end
      end
    end

    if (window_polls != STAMP_MAX) begin
      window_polls++;
    end
    if (full) begin
      closing = 1'b1;
      why     = CLOSE_FULL;
    end else if (saw) begin
      quiet_polls = '0;
    end else if ((chan_on & stamp_valid) != '0) begin
      // quiet timer only runs once an armed channel has seen an edge
      if (quiet_polls != STAMP_MAX) begin
        quiet_polls++;
      end
      if (quiet_polls >= cfg_gap) begin
        closing = 1'b1;
        why     = CLOSE_QUIET;
      end
    end
    if (!closing && window_polls >= cfg_budget) begin
      closing = 1'b1;
      why     = CLOSE_BUDGET;
    end
    if (closing) begin
      chan_on      = '0;
      quiet_polls  = '0;
      window_polls = '0;
      queue_result(KIND_CLOSE, 2'd0, '0, '0, why, 1'b0);
      n++;
    end
    if (n > 0) begin
      due_results[due_results.size()-1].last = 1'b1;
    end
    return n;
  endfunction

  function automatic logic [5:0] draw_capacity();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 6'd0;
    if (roll == 1) return 6'($urandom_range(33, 63));
    if (roll == 2) return 6'($urandom_range(6, 32));
    return 6'($urandom_range(1, 5));
  endfunction

  task automatic send_item(logic [1:0] req, logic [1:0] ch, logic [5:0] cap,
                           logic [3:0] flags, logic [63:0] stamps);
    int pause;
    pause = src_fast ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 23) == 0) begin
      src_fast = !src_fast;
    end
    if (pause > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {4'b0, stamps, flags, cap, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (predict_capture(req, ch, cap, flags, stamps) > 0) begin
      items_active++;
    end
  endtask

  task automatic arm_ch(logic [1:0] ch, logic [5:0] cap);
    send_item(REQ_ARM, ch, cap, 4'($urandom_range(0, 15)), {$urandom, $urandom});
  endtask

  task automatic cancel_ch(logic [1:0] ch);
    send_item(REQ_CANCEL, ch, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
              {$urandom, $urandom});
  endtask

  task automatic poll_item(logic [3:0] flags, logic [63:0] stamps);
    send_item(REQ_POLL, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), flags, stamps);
  endtask

  // hold the input until every result is back, then give in-flight items time
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_QUIET_GAP) begin
      cfg_gap = value;
    end else begin
      cfg_budget = value;
    end
    @(posedge clk_i);
  endtask

  // nothing armed yet: polls and unknown requests are dropped, acks still come
  task automatic test_idle_requests();
    poll_item(4'hF, {$urandom, $urandom});
    send_item(REQ_UNUSED, 2'd3, 6'd63, 4'hF, {$urandom, $urandom});
    arm_ch(2'd1, 6'd0);
    cancel_ch(2'd2);
    settle();
  endtask

  task automatic test_interval_capture();
    arm_ch(2'd0, 6'd63);
    arm_ch(2'd3, 6'd2);
    arm_ch(2'd3, 6'd2);
    // flags on unarmed channels are stale and must be ignored
    poll_item(4'b1111, {16'hFFFF, 16'h1234, 16'hFFFF, 16'h0000});
    poll_item(4'b1001, {16'h0003, 16'h0000, 16'h0000, 16'h0005});
    poll_item(4'b1001, {16'h0003, 16'h0000, 16'h0000, 16'h0005});
    poll_item(4'b1000, {16'h8000, 16'h0000, 16'h0000, 16'h0000});
    cancel_ch(2'd0);
    poll_item(4'b1000, {16'h7FFF, 16'h0000, 16'h0000, 16'h0000});
    settle();
  endtask

  task automatic test_quiet_close();
    write_reg(REG_QUIET_GAP, 16'd1);
    arm_ch(2'd2, 6'd32);
    poll_item(4'b0000, {$urandom, $urandom});
    poll_item(4'b0100, {16'h0000, 16'hABCD, 16'h0000, 16'h0000});
    poll_item(4'b0000, {$urandom, $urandom});
    settle();
    write_reg(REG_QUIET_GAP, 16'd0);
    arm_ch(2'd1, 6'd1);
    poll_item(4'b0010, {$urandom, $urandom});
    poll_item(4'b0000, {$urandom, $urandom});
    settle();
  endtask

  task automatic test_budget_close();
    write_reg(REG_QUIET_GAP, 16'hFFFF);
    write_reg(REG_POLL_BUDGET, 16'd1);
    arm_ch(2'd0, 6'd5);
    poll_item(4'b0001, {$urandom, $urandom});
    settle();
    write_reg(REG_POLL_BUDGET, 16'd0);
    arm_ch(2'd0, 6'd5);
    poll_item(4'b0000, {$urandom, $urandom});
    settle();
    // full and budget together: full wins
    write_reg(REG_POLL_BUDGET, 16'd3);
    arm_ch(2'd3, 6'd1);
    poll_item(4'b1000, {$urandom, $urandom});
    poll_item(4'b1000, {$urandom, $urandom});
    poll_item(4'b0000, {$urandom, $urandom});
    settle();
  endtask

  task automatic run_window();
    int          pick;
    logic [63:0] stamps;
    stamps = {$urandom, $urandom};
    repeat ($urandom_range(1, 4)) arm_ch(2'($urandom_range(0, 3)), draw_capacity());
    repeat ($urandom_range(1, 16)) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        cancel_ch(2'($urandom_range(0, 3)));
      end else if (pick == 1) begin
        arm_ch(2'($urandom_range(0, 3)), draw_capacity());
      end else begin
        // occasionally repeat the stamps so zero intervals show up
        if ($urandom_range(0, 7) != 0) begin
          stamps = {$urandom, $urandom};
        end
        poll_item(($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom_range(0, 15)), stamps);
      end
    end
  endtask

  task automatic run_random_phase(logic [15:0] gap, logic [15:0] budget, int target);
    int goal;
    settle();
    write_reg(REG_QUIET_GAP, gap);
    write_reg(REG_POLL_BUDGET, budget);
    goal = items_sent + target;
    while (items_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                  {$urandom, $urandom});
      end else begin
        run_window();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(16'd5, 16'd24, 80);
    run_random_phase(16'd1, 16'hFFFF, 65);
    run_random_phase(16'hFFFF, 16'd9, 65);
    run_random_phase(16'd0, 16'd0, 25);
    run_random_phase(16'd3, 16'd40, 65);
    settle();
  endtask

  always @(posedge clk_i) begin : result_check
    capture_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected item, kind", m_axis_tuser, -1);
      end else begin
        want = due_results.pop_front();
        if (m_axis_tuser != want.kind)
          report_mismatch("kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[1:0] != want.ch)
          report_mismatch("out_channel", m_axis_tdata[1:0], want.ch);
        if (m_axis_tdata[17:2] != want.interval)
          report_mismatch("interval", m_axis_tdata[17:2], want.interval);
        if (m_axis_tdata[23:18] != want.count)
          report_mismatch("edge_count", m_axis_tdata[23:18], want.count);
        if (m_axis_tdata[25:24] != want.reason)
          report_mismatch("close_reason", m_axis_tdata[25:24], want.reason);
        if (m_axis_tdata[26] != want.acc)
          report_mismatch("accepted", m_axis_tdata[26], want.acc);
        if (m_axis_tdata[31:27] != '0)
          report_mismatch("tdata padding", m_axis_tdata[31:27], 0);
        if (m_axis_tlast != want.last)
          report_mismatch("tlast", m_axis_tlast, want.last);
      end
      if (m_axis_tuser == KIND_CLOSE) begin
        closes[m_axis_tdata[25:24]]++;
      end
      sink_wait = sink_fast ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 23) == 0) begin
        sink_fast = !sink_fast;
      end
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    m_axis_tready <= rst_ni && (sink_wait == 0);
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_idle_requests();
    test_interval_capture();
    test_quiet_close();
    test_budget_close();
    test_random_traffic();
    $display("tb: %0d items sent, %0d with results, %0d results checked in %0d cycles",
             items_sent, items_active, results_seen, cycles);
    $display("tb: windows closed when full %0d, on quiet gap %0d, on budget %0d",
             closes[CLOSE_FULL], closes[CLOSE_QUIET], closes[CLOSE_BUDGET]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
